>>> hw/rtl/text_box_height_checker_core_defines.svh
// Assertion macros for the text box height checker.
// Used by files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef TEXT_BOX_HEIGHT_CHECKER_CORE_DEFINES_SVH
`define TEXT_BOX_HEIGHT_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TBHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TBHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tbhc_pkg.sv
// Shared types and constants of the text box height checker.
// No dependencies; imported by tbhc_track and text_box_height_checker_core.
`default_nettype none

package tbhc_pkg;

  localparam int CoordW   = 12;
  localparam int FrameW   = 14;
  localparam int SizeW    = 13;
  localparam int CfgW     = 13;
  localparam int CfgIdxW  = 2;

  localparam logic [CoordW-1:0] MaxCoord = 12'd4095;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgRecognitionOn    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeightRequired   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHeightRecommended = 2'd2;

  // floor(5*h/3) == (h * Div3Scale) >> 17 for every 12-bit h
  localparam logic [17:0] Div3Scale = 18'd218455;

  typedef enum logic [1:0] {
    ST_PASS  = 2'd0,
    ST_WARN  = 2'd1,
    ST_FAIL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [CoordW-1:0] least_col;
    logic [CoordW-1:0] greatest_col;
    logic [CoordW-1:0] least_row;
    logic [CoordW-1:0] greatest_row;
    logic              seen;
  } box_t;

endpackage

`default_nettype wire

>>> hw/rtl/tbhc_track.sv
// Bounding-box tracker: least/greatest column and row of set mask pixels.
// Depends on tbhc_pkg. Presents the bounds including the word being accepted.
`default_nettype none

module tbhc_track
  import tbhc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [CoordW-1:0] x_offset,
  input  wire logic [CoordW-1:0] y_offset,
  input  wire logic              mask_bit,
  input  wire logic              last_pixel,
  output box_t                   bounds
);

  box_t box_r;
  box_t box_nxt;
  box_t box_clear;

  always_comb begin
    box_clear = '{least_col: MaxCoord, greatest_col: '0,
                  least_row: MaxCoord, greatest_row: '0, seen: 1'b0};
    bounds = box_r;
    if (mask_bit) begin
      if (x_offset < box_r.least_col)    bounds.least_col    = x_offset;
      if (x_offset > box_r.greatest_col) bounds.greatest_col = x_offset;
      if (y_offset < box_r.least_row)    bounds.least_row    = y_offset;
      if (y_offset > box_r.greatest_row) bounds.greatest_row = y_offset;
      bounds.seen = 1'b1;
    end
    box_nxt = box_r;
    if (accept) begin
      // drop the box once its last word is in
      box_nxt = last_pixel ? box_clear : bounds;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= '{least_col: MaxCoord, greatest_col: '0,
                 least_row: MaxCoord, greatest_row: '0, seen: 1'b0};
    end else begin
      box_r <= box_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/text_box_height_checker_core.sv
// Text box height checker: a result becomes valid once the last pixel word of
// a box is accepted and has passed bounds capture, height scaling and grading.
// One pixel word per cycle is accepted while in_stall is low; the three result
// stages close up gaps behind a stalled output, so a waiting result holds up
// input only when all three stages are full. Synchronous active-low reset
// clears the configuration, the tracked bounds and all stage valid flags.
`default_nettype none

module text_box_height_checker_core
  import tbhc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CoordW-1:0]  in_x_offset,
  input  wire logic [CoordW-1:0]  in_y_offset,
  input  wire logic               in_mask_bit,
  input  wire logic               in_last_pixel,
  input  wire logic [CoordW-1:0]  in_box_x,
  input  wire logic [CoordW-1:0]  in_box_y,
  input  wire logic               in_has_ascender,
  input  wire logic               in_has_descender,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic signed [FrameW-1:0] out_x,
  output logic signed [FrameW-1:0] out_y,
  output logic [SizeW-1:0]        out_width,
  output logic [SizeW-1:0]        out_height,
  output logic [SizeW-1:0]        out_measured_height
);

`include "text_box_height_checker_core_defines.svh"

  // configuration
  logic             recog_r;
  logic [CfgW-1:0]  req_r;
  logic [CfgW-1:0]  rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recog_r <= 1'b0;
      req_r   <= '0;
      rec_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CfgRecognitionOn:     recog_r <= cfg_wdata[0];
        CfgHeightRequired:    req_r   <= cfg_wdata;
        CfgHeightRecommended: rec_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage enables
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  logic in_acc;

  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;
  assign in_acc   = in_valid && !in_stall;

  box_t bounds;

  tbhc_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .x_offset   (in_x_offset),
    .y_offset   (in_y_offset),
    .mask_bit   (in_mask_bit),
    .last_pixel (in_last_pixel),
    .bounds     (bounds)
  );

  // stage 1: capture the finished box
  box_t              s1_box_r;
  logic [CoordW-1:0] s1_bx_r, s1_by_r;
  logic              s1_asc_r, s1_desc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_acc && in_last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_box_r  <= bounds;
      s1_bx_r   <= in_box_x;
      s1_by_r   <= in_box_y;
      s1_asc_r  <= in_has_ascender;
      s1_desc_r <= in_has_descender;
    end
  end

  // stage 2: sizes, corner and scaled height
  logic [CoordW-1:0] height;
  logic [CoordW+2:0] height_x5;
  logic [29:0]       height_div3;
  logic [SizeW-1:0]  meas_nxt, width_nxt, hgt_nxt;
  logic [FrameW-1:0] x_nxt, y_nxt;

  always_comb begin
    height      = s1_box_r.greatest_row - s1_box_r.least_row;
    height_x5   = {height, 2'b00} + {3'b000, height};
    height_div3 = {18'd0, height} * {12'd0, Div3Scale};
    meas_nxt    = {1'b0, height};
    if (recog_r) begin
      case ({s1_asc_r, s1_desc_r})
        2'b00:   meas_nxt = height_div3[29:17];
        2'b01,
        2'b10:   meas_nxt = height_x5[14:2];
        default: meas_nxt = {1'b0, height};  // divisor five cancels the scale
      endcase
    end
    width_nxt = {1'b0, s1_box_r.greatest_col} - {1'b0, s1_box_r.least_col} + 13'd2;
    hgt_nxt   = {1'b0, height} + 13'd2;
    x_nxt     = {2'b00, s1_bx_r} + {2'b00, s1_box_r.least_col} - 14'd1;
    y_nxt     = {2'b00, s1_by_r} + {2'b00, s1_box_r.least_row} - 14'd1;
    if (!s1_box_r.seen) begin
      meas_nxt  = '0;
      width_nxt = '0;
      hgt_nxt   = '0;
      x_nxt     = '0;
      y_nxt     = '0;
    end
  end

  logic              s2_seen_r;
  logic [SizeW-1:0]  s2_meas_r, s2_width_r, s2_hgt_r;
  logic [FrameW-1:0] s2_x_r, s2_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_seen_r  <= s1_box_r.seen;
      s2_meas_r  <= meas_nxt;
      s2_width_r <= width_nxt;
      s2_hgt_r   <= hgt_nxt;
      s2_x_r     <= x_nxt;
      s2_y_r     <= y_nxt;
    end
  end

  // stage 3: grade against thresholds into the output register
  status_t status_nxt;

  always_comb begin
    if (!s2_seen_r)              status_nxt = ST_EMPTY;
    else if (s2_meas_r < req_r)  status_nxt = ST_FAIL;
    else if (s2_meas_r < rec_r)  status_nxt = ST_WARN;
    else                         status_nxt = ST_PASS;
  end

  status_t status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      status_r            <= status_nxt;
      out_measured_height <= s2_meas_r;
      out_width           <= s2_width_r;
      out_height          <= s2_hgt_r;
      out_x               <= s2_x_r;
      out_y               <= s2_y_r;
    end
  end

  assign out_valid  = v3_r;
  assign out_status = status_r;

  `TBHC_ASSERT_NOW(a_empty_zero, out_valid && out_status == ST_EMPTY,
    out_width == '0 && out_height == '0 && out_measured_height == '0,
    "empty box result carries nonzero fields")
  `TBHC_ASSERT_NOW(a_pass_meets_req, out_valid && out_status == ST_PASS,
    out_measured_height >= req_r && out_measured_height >= rec_r,
    "pass result below a threshold")
  `TBHC_ASSERT_NOW(a_box_min_size, out_valid && out_status != ST_EMPTY,
    out_width >= 13'd2 && out_height >= 13'd2,
    "nonempty box narrower than padding")
  `TBHC_ASSERT_NOW(a_stall_full, in_stall, v1_r && v2_r && v3_r && out_stall,
    "input stalled with a free stage")
  `TBHC_ASSERT_NEXT(a_track_clear, in_acc && in_last_pixel, !u_track.box_r.seen,
    "tracker not cleared after last word")

endmodule

`default_nettype wire
